/* sv/vbf_pkg.sv */
// Shared constants, control struct and fixed-point helpers for the voice-band filter.
package vbf_pkg;

	// State format: signed 32 bits with this many fraction bits
	localparam int STATE_FRACTION_BITS = 24;
	localparam int IN_SHIFT = STATE_FRACTION_BITS - 15;
	localparam int COEF_SHIFT = 16;

	// Shared multiplier widths: signed operand times unsigned 16-bit value
	localparam int OPA_W = 35;
	localparam int OPB_W = 16;
	localparam int PROD_W = OPA_W + OPB_W + 1;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_HP_ALPHA = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LP_ALPHA = CFG_IDX_W'(1);
	localparam logic [15:0] HP_ALPHA_RST = 16'd63540;
	localparam logic [15:0] LP_ALPHA_RST = 16'd39240;

	// Output gain applied to the clamped low-pass value
	localparam logic [OPB_W-1:0] OUT_GAIN = OPB_W'(32767);

	// Full scale (one) in state format
	localparam logic signed [OPA_W-1:0] STATE_ONE = OPA_W'(64'sd1 <<< STATE_FRACTION_BITS);

	// Sequencer to datapath controls
	typedef struct packed {
		logic load_in;   // item accepted: form the high-pass difference
		logic do_hp;     // product holds the high-pass term
		logic do_lp;     // product holds the low-pass term
		logic do_out;    // product holds the output term, output register free
	} vbf_ctl_t;

	// Divide by 2^s, round to nearest, ties away from zero
	function automatic logic signed [PROD_W-1:0] round_shift(
		input logic signed [PROD_W-1:0] v,
		input int unsigned s
	);
		logic neg;
		logic [PROD_W-1:0] mag;
		neg = v[PROD_W-1];
		mag = neg ? PROD_W'(-v) : PROD_W'(v);
		mag = (mag + (PROD_W'(1) << (s - 1))) >> s;
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	// Saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] max_v;
		logic signed [PROD_W-1:0] min_v;
		max_v = PROD_W'(64'sh7FFF_FFFF);
		min_v = -PROD_W'(64'sh8000_0000);
		if (v > max_v) begin
			return 32'sh7FFF_FFFF;
		end else if (v < min_v) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

/* sv/voice_band_iir_filter.sv */
// Top level: first-order high-pass then low-pass voice-band filter, one shared multiplier.
//
// Usage:
//  - Input channel (in_valid/in_ready, sample_in): one signed 16-bit PCM sample
//    per item. in_ready is high only while the sequencer is idle.
//  - Output channel (out_valid/out_ready, sample_out): one filtered sample per
//    input item, held in an output register until taken.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
//    high-pass alpha, index 1 the low-pass alpha (unsigned Q0.16). cfg_ready
//    is always high; other indexes are ignored. Write only while idle.
//  - Timing: from acceptance to out_valid an item steps through the states
//    MHP, HP, MLP, LP, MOUT and OUT, and the next item is taken the cycle
//    after the result is loaded, so one item is in flight at a time. The
//    steps are set by three dependent products (high-pass, low-pass, output
//    gain) through the one multiplier, each a multiply and a round/saturate state.
//  - Stall: while the output register is full and out_ready is low, the last
//    step waits; the next input is accepted once that result is loaded.
//  - Reset: filter state clears to zero, alphas return to their defaults
//    (80 Hz and 3800 Hz at 16 kHz), no result pending.
module voice_band_iir_filter
	import vbf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   sample_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   sample_out
);

	logic [15:0]              hp_alpha_q;
	logic [15:0]              lp_alpha_q;
	logic signed [15:0]       prior_q;
	logic signed [31:0]       hp_q;
	logic signed [31:0]       lp_q;
	logic signed [OPA_W-1:0]  op_a_q;
	logic        [OPB_W-1:0]  op_b_q;
	logic signed [PROD_W-1:0] prod;
	logic                     out_valid_q;
	logic signed [15:0]       out_q;
	logic                     out_free;
	vbf_ctl_t                 ctl;

	logic signed [OPA_W-1:0]  diff_in;
	logic signed [31:0]       hp_new;
	logic signed [31:0]       lp_new;
	logic signed [PROD_W-1:0] lp_sum;
	logic signed [OPA_W-1:0]  lp_clamp;
	logic signed [PROD_W-1:0] y_full;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	vbf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.ctl      (ctl)
	);

	vbf_mul u_mul (
		.clk  (clk),
		.op_a (op_a_q),
		.op_b (op_b_q),
		.prod (prod)
	);

	// High-pass difference: hp_prev + x - x_prev, inputs scaled to state format
	assign diff_in = OPA_W'(hp_q)
		+ (OPA_W'(sample_in) <<< IN_SHIFT)
		- (OPA_W'(prior_q) <<< IN_SHIFT);

	// Round each product; saturate the high-pass and low-pass results
	assign hp_new = sat32(round_shift(prod, COEF_SHIFT));
	assign lp_sum = PROD_W'(lp_q) + round_shift(prod, COEF_SHIFT);
	assign lp_new = sat32(lp_sum);
	assign y_full = round_shift(prod, STATE_FRACTION_BITS);

	// Clamp new low-pass value to [-1, 1]
	always_comb begin
		lp_clamp = OPA_W'(lp_new);
		if (lp_clamp > STATE_ONE) begin
			lp_clamp = STATE_ONE;
		end else if (lp_clamp < -STATE_ONE) begin
			lp_clamp = -STATE_ONE;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_alpha_q <= HP_ALPHA_RST;
			lp_alpha_q <= LP_ALPHA_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HP_ALPHA: hp_alpha_q <= cfg_data;
				CFG_LP_ALPHA: lp_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q <= '0;
			hp_q    <= '0;
			lp_q    <= '0;
		end else begin
			if (ctl.load_in) prior_q <= sample_in;
			if (ctl.do_hp)   hp_q    <= hp_new;
			if (ctl.do_lp)   lp_q    <= lp_new;
		end
	end

	// Multiplier operands for the next product
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			op_a_q <= diff_in;
			op_b_q <= hp_alpha_q;
		end else if (ctl.do_hp) begin
			op_a_q <= OPA_W'(hp_new) - OPA_W'(lp_q);
			op_b_q <= lp_alpha_q;
		end else if (ctl.do_lp) begin
			op_a_q <= lp_clamp;
			op_b_q <= OUT_GAIN;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.do_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.do_out) out_q <= y_full[15:0];
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule

/* sv/vbf_mul.sv */
// Shared multiplier with registered product.
module vbf_mul
	import vbf_pkg::*;
(
	input  logic                     clk,
	input  logic signed [OPA_W-1:0]  op_a,
	input  logic        [OPB_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	// Unsigned coefficient widened with a zero sign bit
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a * $signed({1'b0, op_b}));
	end

	assign prod = prod_q;

endmodule

/* sv/vbf_seq.sv */
// Sequencer stepping one item through the shared multiplier.
module vbf_seq
	import vbf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_free,
	output vbf_ctl_t ctl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MHP  = 3'd1;
	localparam logic [2:0] ST_HP   = 3'd2;
	localparam logic [2:0] ST_MLP  = 3'd3;
	localparam logic [2:0] ST_LP   = 3'd4;
	localparam logic [2:0] ST_MOUT = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Controls decoded from the state
	always_comb begin
		ctl.load_in = (state_q == ST_IDLE) && in_valid;
		ctl.do_hp   = (state_q == ST_HP);
		ctl.do_lp   = (state_q == ST_LP);
		ctl.do_out  = (state_q == ST_OUT) && out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MHP;
			ST_MHP:  state_d = ST_HP;
			ST_HP:   state_d = ST_MLP;
			ST_MLP:  state_d = ST_LP;
			ST_LP:   state_d = ST_MOUT;
			ST_MOUT: state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
